// File: rtl/wbrp_pkg.sv
// Shared types and constants for the write batch record parser.
// Used by wbrp_core and write_batch_record_parser_top; depends on nothing.
package wbrp_pkg;

  localparam int unsigned HdrBytes = 12;
  localparam int unsigned SeqBytes = 8;

  localparam logic [3:0] HDR_LAST_POS = 4'(HdrBytes - 1);
  localparam logic [3:0] SEQ_BYTES    = 4'(SeqBytes);

  localparam logic [2:0] ROLE_SEQ_HDR   = 3'd0;
  localparam logic [2:0] ROLE_CNT_HDR   = 3'd1;
  localparam logic [2:0] ROLE_TAG       = 3'd2;
  localparam logic [2:0] ROLE_KEY_LEN   = 3'd3;
  localparam logic [2:0] ROLE_KEY_DATA  = 3'd4;
  localparam logic [2:0] ROLE_VAL_LEN   = 3'd5;
  localparam logic [2:0] ROLE_VAL_DATA  = 3'd6;
  localparam logic [2:0] ROLE_IGNORED   = 3'd7;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
  localparam logic [2:0] ST_BAD_PUT     = 3'd2;
  localparam logic [2:0] ST_BAD_DELETE  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_TAG = 3'd4;
  localparam logic [2:0] ST_WRONG_COUNT = 3'd5;

  localparam logic [7:0] CFG_TAG_PUT    = 8'd0;
  localparam logic [7:0] CFG_TAG_DELETE = 8'd1;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [31:0] record_index;
    logic        record_kind;
    logic [63:0] record_sequence;
    logic        record_end;
    logic [2:0]  status;
  } wbrp_result_t;

endpackage

// File: rtl/wbrp_core.sv
// Parser state and per-item labelling logic of the write batch record parser.
// Depends on wbrp_pkg; the result is combinational from the state and the item.
module wbrp_core
  import wbrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  input  logic [7:0]   tag_put,
  input  logic [7:0]   tag_delete,
  output wbrp_result_t result
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_TAG, PH_KEYLEN, PH_KEYDATA, PH_VALLEN, PH_VALDATA, PH_FAILED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic [63:0] start_seq_r, start_seq_nxt;
  logic [31:0] declared_r, declared_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  vnum_r, vnum_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] found_r, found_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [4:0]  shamt;
  logic [31:0] acc_or;
  logic [31:0] remain_dec;
  logic        is_key;
  logic        in_record;

  always_comb begin
    unique case (vnum_r)
      3'd0:    shamt = 5'd0;
      3'd1:    shamt = 5'd7;
      3'd2:    shamt = 5'd14;
      3'd3:    shamt = 5'd21;
      3'd4:    shamt = 5'd28;
      default: shamt = 5'd0;
    endcase
  end

  assign acc_or     = acc_r | ({25'd0, in_byte[6:0]} << shamt);
  assign remain_dec = remain_r - 32'd1;
  assign in_record  = (phase_r != PH_HEADER) && (phase_r != PH_FAILED);
  assign is_key     = (phase_r == PH_KEYLEN) || (phase_r == PH_KEYDATA);

  always_comb begin
    phase_nxt     = phase_r;
    hdr_pos_nxt   = hdr_pos_r;
    start_seq_nxt = start_seq_r;
    declared_nxt  = declared_r;
    acc_nxt       = acc_r;
    vnum_nxt      = vnum_r;
    remain_nxt    = remain_r;
    kind_nxt      = kind_r;
    found_nxt     = found_r;
    err_nxt       = err_r;

    result = '0;
    result.byte_role = ROLE_IGNORED;
    if (in_record) begin
      result.record_index    = found_r;
      result.record_sequence = start_seq_r + {32'd0, found_r};
    end

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_pos_r < SEQ_BYTES) begin
          result.byte_role = ROLE_SEQ_HDR;
          start_seq_nxt[{hdr_pos_r[2:0], 3'b000} +: 8] = in_byte;
        end else begin
          result.byte_role = ROLE_CNT_HDR;
          declared_nxt[{hdr_pos_r[1:0], 3'b000} +: 8] = in_byte;
        end
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        if (hdr_pos_r == HDR_LAST_POS) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_TAG: begin
        result.byte_role = ROLE_TAG;
        acc_nxt  = '0;
        vnum_nxt = '0;
        if (in_byte == tag_put) begin
          kind_nxt  = 1'b0;
          phase_nxt = PH_KEYLEN;
        end else if (in_byte == tag_delete) begin
          kind_nxt  = 1'b1;
          phase_nxt = PH_KEYLEN;
        end else begin
          kind_nxt  = 1'b0;
          acc_nxt   = acc_r;
          vnum_nxt  = vnum_r;
          err_nxt   = ST_UNKNOWN_TAG;
          phase_nxt = PH_FAILED;
        end
        result.record_kind = kind_nxt;
      end
      PH_KEYLEN, PH_VALLEN: begin
        result.byte_role   = is_key ? ROLE_KEY_LEN : ROLE_VAL_LEN;
        result.record_kind = kind_r;
        if (vnum_r >= 3'd4 && in_byte[7]) begin
          err_nxt   = kind_r ? ST_BAD_DELETE : ST_BAD_PUT;
          phase_nxt = PH_FAILED;
        end else begin
          acc_nxt = acc_or;
          if (in_byte[7]) begin
            vnum_nxt = vnum_r + 3'd1;
          end else if (acc_or == 32'd0) begin
            if (is_key && !kind_r) begin
              acc_nxt   = '0;
              vnum_nxt  = '0;
              phase_nxt = PH_VALLEN;
            end else begin
              found_nxt         = found_r + 32'd1;
              phase_nxt         = PH_TAG;
              result.record_end = 1'b1;
            end
          end else begin
            remain_nxt = acc_or;
            phase_nxt  = is_key ? PH_KEYDATA : PH_VALDATA;
          end
        end
      end
      PH_KEYDATA, PH_VALDATA: begin
        result.byte_role   = is_key ? ROLE_KEY_DATA : ROLE_VAL_DATA;
        result.record_kind = kind_r;
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          if (is_key && !kind_r) begin
            acc_nxt   = '0;
            vnum_nxt  = '0;
            phase_nxt = PH_VALLEN;
          end else begin
            found_nxt         = found_r + 32'd1;
            phase_nxt         = PH_TAG;
            result.record_end = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    result.status = err_nxt;
    if (in_last) begin
      if (err_nxt != ST_OK) begin
        result.status = err_nxt;
      end else if (phase_nxt == PH_HEADER) begin
        result.status = ST_TOO_SMALL;
      end else if (phase_nxt != PH_TAG) begin
        result.status = kind_nxt ? ST_BAD_DELETE : ST_BAD_PUT;
      end else if (found_nxt != declared_nxt) begin
        result.status = ST_WRONG_COUNT;
      end else begin
        result.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_last)) begin
      phase_r     <= PH_HEADER;
      hdr_pos_r   <= '0;
      start_seq_r <= '0;
      declared_r  <= '0;
      acc_r       <= '0;
      vnum_r      <= '0;
      remain_r    <= '0;
      kind_r      <= 1'b0;
      found_r     <= '0;
      err_r       <= ST_OK;
    end else if (step) begin
      phase_r     <= phase_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      start_seq_r <= start_seq_nxt;
      declared_r  <= declared_nxt;
      acc_r       <= acc_nxt;
      vnum_r      <= vnum_nxt;
      remain_r    <= remain_nxt;
      kind_r      <= kind_nxt;
      found_r     <= found_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// File: rtl/write_batch_record_parser_top.sv
// Top level of the write batch record parser: stream ports, tag registers, result register.
// Depends on wbrp_pkg and wbrp_core.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata byte, in_tlast end of batch
//   out_     master     out_tvalid/out_tready out_tdata labels, out_tuser role/kind
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle; its result appears in the result register on the next cycle.
// The result register is the only stage, so the input stalls only while a held result is
// not taken. Reset is synchronous; it clears the parser state, sets the put tag to 1
// and the delete tag to 0. The configuration port is always ready.
module write_batch_record_parser_top
  import wbrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] in_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,   // [7:0] out_byte, [39:8] record_index,
                                    // [103:40] record_sequence, [104] record_end,
                                    // [107:105] status, [111:108] zero
  output logic [3:0]   out_tuser,   // [2:0] byte_role, [3] record_kind
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  logic         accept;
  logic [7:0]   tag_put_r;
  logic [7:0]   tag_delete_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  wbrp_result_t result;
  wbrp_result_t result_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_put_r    <= 8'd1;
      tag_delete_r <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TAG_PUT:    tag_put_r    <= cfg_data;
        CFG_TAG_DELETE: tag_delete_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wbrp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .tag_put    (tag_put_r),
    .tag_delete (tag_delete_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r   <= result;
      out_byte_r <= in_tdata;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {result_r.record_kind, result_r.byte_role};
  assign out_tdata  = {4'd0, result_r.status, result_r.record_end,
                       result_r.record_sequence, result_r.record_index, out_byte_r};

endmodule

// File: sim/write_batch_record_parser_top_test.sv
// Self-checking testbench for write_batch_record_parser_top: streams serialized batches
// byte by byte, predicts every label in a behavioral parser and checks each result item.
// Depends on wbrp_pkg and the RTL of write_batch_record_parser_top.
`timescale 1ns / 100ps

module write_batch_record_parser_top_test;
  import wbrp_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseBytes  = 90;
  localparam int unsigned IdlePercent = 34;

  typedef enum logic [2:0] {
    P_HEADER, P_TAG, P_KEY_LEN, P_KEY_DATA, P_VAL_LEN, P_VAL_DATA, P_FAILED
  } parse_phase_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [2:0]  role;
    logic [7:0]  data;
    logic [31:0] index;
    logic        kind;
    logic [63:0] seq;
    logic        rend;
    logic        last;
    logic [2:0]  status;
  } byte_label_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } batch_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  // Parser state as the testbench sees it.
  parse_phase_t ph;
  logic [3:0]   hdr_pos;
  logic [63:0]  start_seq;
  logic [31:0]  decl_count;
  logic [31:0]  vint_acc;
  logic [2:0]   vint_num;
  logic [31:0]  remaining;
  logic         cur_del;
  logic [31:0]  found;
  logic [2:0]   err;
  logic [7:0]   put_tag;
  logic [7:0]   del_tag;

  byte_label_t  expected_labels[$];
  batch_byte_t  pending_bytes[$];
  logic [7:0]   batch_q[$];

  int unsigned  queued_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  fail_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  hold_orders = 0;
  int unsigned  hold_served = 0;
  int unsigned  hold_left = 0;
  logic         steady = 1'b0;

  write_batch_record_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic clear_parser();
    ph = P_HEADER;
    hdr_pos = '0;
    start_seq = '0;
    decl_count = '0;
    vint_acc = '0;
    vint_num = '0;
    remaining = '0;
    cur_del = 1'b0;
    found = '0;
    err = ST_OK;
  endtask

  function automatic logic close_field(input logic was_key);
    if (was_key && !cur_del) begin
      vint_acc = '0;
      vint_num = '0;
      ph = P_VAL_LEN;
      return 1'b0;
    end
    found = found + 32'd1;
    ph = P_TAG;
    return 1'b1;
  endfunction

  task automatic label_byte(input logic [7:0] b, input logic last);
    byte_label_t lab;
    logic        is_key;
    lab = '0;
    lab.role = ROLE_IGNORED;
    lab.data = b;
    lab.last = last;
    if (ph != P_HEADER && ph != P_FAILED) begin
      lab.index = found;
      lab.seq = start_seq + 64'(found);
    end
    case (ph)
      P_HEADER: begin
        if (hdr_pos < SEQ_BYTES) begin
          lab.role = ROLE_SEQ_HDR;
          start_seq |= 64'(b) << (8 * hdr_pos);
        end else begin
          lab.role = ROLE_CNT_HDR;
          decl_count |= 32'(b) << (8 * (hdr_pos - SEQ_BYTES));
        end
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos == HdrBytes) ph = P_TAG;
      end
      P_TAG: begin
        lab.role = ROLE_TAG;
        if (b == put_tag || b == del_tag) begin
          cur_del = (b != put_tag);
          vint_acc = '0;
          vint_num = '0;
          ph = P_KEY_LEN;
        end else begin
          cur_del = 1'b0;
          err = ST_UNKNOWN_TAG;
          ph = P_FAILED;
        end
        lab.kind = cur_del;
      end
      P_KEY_LEN, P_VAL_LEN: begin
        is_key = (ph == P_KEY_LEN);
        lab.role = is_key ? ROLE_KEY_LEN : ROLE_VAL_LEN;
        lab.kind = cur_del;
        if (vint_num >= 3'd4 && b[7]) begin
          err = cur_del ? ST_BAD_DELETE : ST_BAD_PUT;
          ph = P_FAILED;
        end else begin
          vint_acc |= 32'(b[6:0]) << (7 * vint_num);
          if (b[7]) begin
            vint_num = vint_num + 3'd1;
          end else if (vint_acc == '0) begin
            lab.rend = close_field(is_key);
          end else begin
            remaining = vint_acc;
            ph = is_key ? P_KEY_DATA : P_VAL_DATA;
          end
        end
      end
      P_KEY_DATA, P_VAL_DATA: begin
        is_key = (ph == P_KEY_DATA);
        lab.role = is_key ? ROLE_KEY_DATA : ROLE_VAL_DATA;
        lab.kind = cur_del;
        remaining = remaining - 32'd1;
        if (remaining == '0) lab.rend = close_field(is_key);
      end
      default: ;
    endcase
    lab.status = err;
    if (last) begin
      if (err != ST_OK) lab.status = err;
      else if (ph == P_HEADER) lab.status = ST_TOO_SMALL;
      else if (ph != P_TAG) lab.status = cur_del ? ST_BAD_DELETE : ST_BAD_PUT;
      else if (found != decl_count) lab.status = ST_WRONG_COUNT;
      else lab.status = ST_OK;
      clear_parser();
    end
    expected_labels.insert(expected_labels.size(), lab);
  endtask

  always @(posedge clk) begin : driver
    batch_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) label_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= IdlePercent)) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    byte_label_t want;
    byte_label_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked_count++;
        got.pad    = out_tdata[111:108];
        got.role   = out_tuser[2:0];
        got.data   = out_tdata[7:0];
        got.index  = out_tdata[39:8];
        got.kind   = out_tuser[3];
        got.seq    = out_tdata[103:40];
        got.rend   = out_tdata[104];
        got.last   = out_tlast;
        got.status = out_tdata[107:105];
        if (expected_labels.size() == 0) begin
          if (fail_count < 10) $display("%0t: result item with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_labels.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch (role byte index kind seq end last status pad)", $time);
              $display("  expected %0d %h %0d %0d %h %0d %0d %0d %h", want.role, want.data,
                       want.index, want.kind, want.seq, want.rend, want.last, want.status,
                       want.pad);
              $display("  actual   %0d %h %0d %0d %h %0d %0d %0d %h", got.role, got.data,
                       got.index, got.kind, got.seq, got.rend, got.last, got.status, got.pad);
            end
            fail_count++;
          end
        end
      end
      if (hold_orders != hold_served) begin
        hold_served = hold_orders;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_batch();
    batch_byte_t item;
    foreach (batch_q[i]) begin
      item.data = batch_q[i];
      item.last = (i == batch_q.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
    end
    queued_count += batch_q.size();
  endtask

  task automatic add_byte(input logic [7:0] v);
    batch_q.insert(batch_q.size(), v);
  endtask

  task automatic add_length(input int unsigned len);
    int unsigned minb;
    int unsigned nb;
    int unsigned mode;
    logic [7:0]  v;
    minb = (len < 128) ? 1 : (len < 16384) ? 2 : 3;
    mode = $urandom_range(99);
    nb = (mode < 85) ? minb : (mode < 95) ? $urandom_range(5, minb) : 5;
    for (int unsigned i = 0; i < nb; i++) begin
      v = 8'((len >> (7 * i)) & 32'h7f);
      if (i < nb - 1) v[7] = 1'b1;
      if (i == 4 && mode >= 95) v[6:4] = 3'($urandom);
      add_byte(v);
    end
  endtask

  task automatic add_bad_length();
    repeat (5) add_byte({1'b1, 7'($urandom)});
    repeat ($urandom_range(3)) add_byte(8'($urandom));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 90) return $urandom_range(6, 1);
    if (r < 97) return $urandom_range(40, 7);
    return $urandom_range(300, 120);
  endfunction

  task automatic make_batch();
    int unsigned mode;
    int unsigned nrec;
    int unsigned r;
    int unsigned klen;
    int unsigned vlen;
    logic [63:0] seq;
    logic [31:0] cnt;
    logic [7:0]  tag;
    logic        is_del;
    logic        failed;
    batch_q.delete();
    mode = $urandom_range(99);
    if (mode < 7) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
    end else if (mode < 11) begin
      repeat ($urandom_range(24, 1)) add_byte(8'($urandom));
    end else begin
      seq = {$urandom, $urandom};
      if ($urandom_range(3) == 0) seq = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(3));
      nrec = $urandom_range(4);
      cnt = nrec;
      r = $urandom_range(99);
      if (r < 8) cnt = nrec + $urandom_range(2, 1);
      else if (r < 11) cnt = $urandom;
      for (int i = 0; i < 8; i++) add_byte(seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) add_byte(cnt[8*i +: 8]);
      failed = 1'b0;
      for (int unsigned i = 0; i < nrec && !failed; i++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          add_byte(8'($urandom));
          repeat ($urandom_range(3)) add_byte(8'($urandom));
          failed = 1'b1;
        end else begin
          tag = $urandom_range(1) ? del_tag : put_tag;
          is_del = (tag != put_tag);
          add_byte(tag);
          if (r < 8) begin
            add_bad_length();
            failed = 1'b1;
          end else begin
            klen = pick_len();
            add_length(klen);
            repeat (klen) add_byte(8'($urandom));
            if (!is_del) begin
              if (r < 11) begin
                add_bad_length();
                failed = 1'b1;
              end else begin
                vlen = pick_len();
                add_length(vlen);
                repeat (vlen) add_byte(8'($urandom));
              end
            end
          end
        end
      end
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(batch_q.size() - 1, 1)) void'(batch_q.pop_back());
    end
  endtask

  task automatic write_tag(input logic [7:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_TAG_PUT) put_tag = value;
    else if (index == CFG_TAG_DELETE) del_tag = value;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    wait (checked_count == queued_count);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned fill;
    put_tag = 8'd1;
    del_tag = 8'd0;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A lone byte, then a batch with a wrapping sequence, an empty delete key,
    // a put with one key byte and an empty value.
    batch_q = '{8'hff};
    push_batch();
    batch_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'h02, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00,
                8'h01, 8'h01, 8'h80, 8'h00};
    push_batch();

    for (int unsigned phase_no = 0; phase_no < NumPhases; phase_no++) begin
      if (phase_no != 0) begin
        wait_drained();
        case (phase_no)
          1: begin
            write_tag(CFG_TAG_PUT, 8'hff);
            write_tag(CFG_TAG_DELETE, 8'h00);
          end
          2: begin
            write_tag(CFG_TAG_PUT, 8'h00);
            write_tag(CFG_TAG_DELETE, 8'hff);
          end
          3: begin
            write_tag(CFG_TAG_PUT, 8'h5a);
            write_tag(CFG_TAG_DELETE, 8'h5a);
            write_tag(8'($urandom_range(255, CFG_TAG_DELETE + 1)), 8'($urandom));
          end
          4: begin
            write_tag(CFG_TAG_PUT, 8'h80);
            write_tag(CFG_TAG_DELETE, 8'h7f);
          end
          default: begin
            write_tag(CFG_TAG_PUT, 8'($urandom));
            write_tag(CFG_TAG_DELETE, 8'($urandom));
          end
        endcase
      end
      steady = (phase_no == 4);
      fill = queued_count + PhaseBytes;
      while (queued_count < fill) begin
        make_batch();
        push_batch();
      end
      if (phase_no == 5) hold_orders++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_labels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
